>>> sv/tmds_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the tape machine debug stepper.
// No dependencies; the controller, datapath and top refer to it by scoped names.
package tmds_pkg;

   localparam int TAPE_DEPTH_DEF  = 4096;
   localparam int BREAK_SLOTS_DEF = 16;

   localparam logic [2:0] CMD_LOAD    = 3'd0;
   localparam logic [2:0] CMD_ADD     = 3'd1;
   localparam logic [2:0] CMD_REMOVE  = 3'd2;
   localparam logic [2:0] CMD_STEP    = 3'd3;
   localparam logic [2:0] CMD_RESTART = 3'd4;

   localparam logic [2:0] ST_DONE      = 3'd0;
   localparam logic [2:0] ST_STEPPED   = 3'd1;
   localparam logic [2:0] ST_OUTPUT    = 3'd2;
   localparam logic [2:0] ST_BREAK     = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;
   localparam logic [2:0] ST_UNMATCHED = 3'd6;
   localparam logic [2:0] ST_END       = 3'd7;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_RIGHT = 8'h3E;
   localparam logic [7:0] CH_LEFT  = 8'h3C;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COMMA = 8'h2C;

   typedef struct packed {
      logic [2:0]  command;
      logic [11:0] address;
      logic [7:0]  value;
      logic        ignore_breakpoint;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  out_byte;
      logic [11:0] program_counter;
      logic [11:0] data_pointer;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH_OP,
      S_FETCH_CELL,
      S_EXEC,
      S_SCAN_FIRST,
      S_SCAN
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic fetch_op;
      logic fetch_cell;
      logic exec;
      logic scan_start;
      logic scan_step;
   } ctl_type;

   typedef struct packed {
      logic clear_last;
      logic is_step;
      logic scan_begin;
      logic scan_end;
   } stat_type;

endpackage

>>> sv/tmds_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module tmds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> sv/tmds_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences the clearing pass, command acceptance,
// instruction fetch, execute and bracket scan. Depends on tmds_pkg.
module tmds_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  tmds_pkg::stat_type stat,
   output tmds_pkg::ctl_type  ctl
);

   tmds_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmds_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tmds_pkg::S_CLEAR: begin
            if (stat.clear_last) state_in = tmds_pkg::S_IDLE;
         end
         tmds_pkg::S_IDLE: begin
            if (start && stat.is_step) state_in = tmds_pkg::S_FETCH_OP;
         end
         tmds_pkg::S_FETCH_OP:   state_in = tmds_pkg::S_FETCH_CELL;
         tmds_pkg::S_FETCH_CELL: state_in = tmds_pkg::S_EXEC;
         tmds_pkg::S_EXEC: begin
            state_in = stat.scan_begin ? tmds_pkg::S_SCAN_FIRST : tmds_pkg::S_IDLE;
         end
         tmds_pkg::S_SCAN_FIRST: state_in = tmds_pkg::S_SCAN;
         tmds_pkg::S_SCAN: begin
            if (stat.scan_end) state_in = tmds_pkg::S_IDLE;
         end
         default: state_in = tmds_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      ctl            = '0;
      busy           = (state_ff != tmds_pkg::S_IDLE);
      ctl.clear_step = (state_ff == tmds_pkg::S_CLEAR);
      ctl.accept     = (state_ff == tmds_pkg::S_IDLE) && start;
      ctl.fetch_op   = (state_ff == tmds_pkg::S_FETCH_OP);
      ctl.fetch_cell = (state_ff == tmds_pkg::S_FETCH_CELL);
      ctl.exec       = (state_ff == tmds_pkg::S_EXEC);
      ctl.scan_start = (state_ff == tmds_pkg::S_SCAN_FIRST);
      ctl.scan_step  = (state_ff == tmds_pkg::S_SCAN);
   end

endmodule

>>> sv/tmds_dpath.sv
`timescale 1ns / 1ps
// Datapath: tape RAM, pointers, breakpoint table, bracket scan and result
// register. Depends on tmds_pkg and tmds_ram. The user must keep TAPE_DEPTH a power of two; it is not checked here.
module tmds_dpath #(
   parameter int TAPE_DEPTH  = tmds_pkg::TAPE_DEPTH_DEF,
   parameter int BREAK_SLOTS = tmds_pkg::BREAK_SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  tmds_pkg::ctl_type  ctl,
   output tmds_pkg::stat_type stat,
   input  tmds_pkg::req_type  req_data,
   input  logic               csr_we,
   input  logic [11:0]        csr_wdata,
   output logic               rsp_valid,
   output tmds_pkg::rsp_type  rsp_data
);

   localparam int AW = $clog2(TAPE_DEPTH);
   localparam int CW = $clog2(BREAK_SLOTS + 1);
   localparam int IW = (BREAK_SLOTS > 1) ? $clog2(BREAK_SLOTS) : 1;
   localparam int KW = (AW > 12) ? AW : 12;
   localparam logic [AW-1:0] LAST = AW'(TAPE_DEPTH - 1);

   logic [AW-1:0] pc_ff, pc_in, dp_ff, dp_in;
   logic [11:0]   plen_ff;
   logic [11:0]   bp_ff [BREAK_SLOTS];
   logic [11:0]   bp_in [BREAK_SLOTS];
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [7:0]    op_ff, op_in;
   logic          ign_ff, ign_in, hit_ff, hit_in, dir_ff, dir_in;
   logic [AW-1:0] scan_ptr_ff, scan_ptr_in, chk_ff, chk_in;
   logic [AW:0]   depth_ff, depth_in;
   logic          rsp_valid_ff, rsp_valid_in;
   tmds_pkg::rsp_type rsp_ff, rsp_in;

   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [7:0]    wdata, rdata;

   logic [KW-1:0] key;
   logic          found;
   logic [IW-1:0] idx;
   logic [2:0]    st;
   logic [7:0]    ob;
   logic [7:0]    inc_ch, dec_ch;
   logic          scan_begin, scan_end;

   tmds_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   // first valid breakpoint entry equal to the key
   always_comb begin
      key   = ctl.fetch_op ? KW'(pc_ff) : KW'(req_data.address);
      found = 1'b0;
      idx   = '0;
      for (int i = 0; i < BREAK_SLOTS; i++) begin
         if (!found && (CW'(i) < cnt_ff) && (KW'(bp_ff[i]) == key)) begin
            found = 1'b1;
            idx   = IW'(i);
         end
      end
   end

   always_comb begin
      pc_in        = pc_ff;
      dp_in        = dp_ff;
      bp_in        = bp_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      ign_in       = ign_ff;
      hit_in       = hit_ff;
      dir_in       = dir_ff;
      scan_ptr_in  = scan_ptr_ff;
      chk_in       = chk_ff;
      depth_in     = depth_ff;
      rsp_valid_in = 1'b0;
      st           = tmds_pkg::ST_DONE;
      ob           = 8'd0;
      we           = 1'b0;
      waddr        = dp_ff;
      wdata        = 8'd0;
      raddr        = pc_ff;
      scan_begin   = 1'b0;
      scan_end     = 1'b0;
      inc_ch       = dir_ff ? tmds_pkg::CH_OPEN : tmds_pkg::CH_CLOSE;
      dec_ch       = dir_ff ? tmds_pkg::CH_CLOSE : tmds_pkg::CH_OPEN;

      if (ctl.clear_step) begin
         we     = 1'b1;
         waddr  = clr_ff;
         clr_in = clr_ff + 1'b1;
      end

      if (ctl.accept) begin
         ign_in       = req_data.ignore_breakpoint;
         rsp_valid_in = (req_data.command != tmds_pkg::CMD_STEP);
         case (req_data.command)
            tmds_pkg::CMD_LOAD: begin
               we    = 1'b1;
               waddr = AW'(req_data.address);
               wdata = req_data.value;
            end
            tmds_pkg::CMD_ADD: begin
               if (cnt_ff == CW'(BREAK_SLOTS)) begin
                  st = tmds_pkg::ST_FULL;
               end else begin
                  bp_in[cnt_ff[IW-1:0]] = req_data.address;
                  cnt_in                = cnt_ff + 1'b1;
               end
            end
            tmds_pkg::CMD_REMOVE: begin
               if (!found) begin
                  st = tmds_pkg::ST_NOT_FOUND;
               end else begin
                  // close the gap left by the removed entry
                  for (int k = 0; k < BREAK_SLOTS - 1; k++) begin
                     if ((IW'(k) >= idx) && (CW'(k + 1) < cnt_ff)) begin
                        bp_in[k] = bp_ff[k + 1];
                     end
                  end
                  cnt_in = cnt_ff - 1'b1;
               end
            end
            tmds_pkg::CMD_RESTART: begin
               pc_in = '0;
               dp_in = AW'(plen_ff);
            end
            default: ;
         endcase
      end

      if (ctl.fetch_op) begin
         raddr  = pc_ff;
         hit_in = found;
      end

      if (ctl.fetch_cell) begin
         raddr = dp_ff;
         op_in = rdata;
      end

      if (ctl.exec) begin
         if (!ign_ff && hit_ff) begin
            st           = tmds_pkg::ST_BREAK;
            rsp_valid_in = 1'b1;
         end else begin
            st = tmds_pkg::ST_STEPPED;
            unique case (op_ff)
               tmds_pkg::CH_PLUS: begin
                  we    = 1'b1;
                  wdata = rdata + 8'd1;
               end
               tmds_pkg::CH_MINUS: begin
                  we    = 1'b1;
                  wdata = rdata - 8'd1;
               end
               tmds_pkg::CH_RIGHT: dp_in = dp_ff + 1'b1;
               tmds_pkg::CH_LEFT:  dp_in = dp_ff - 1'b1;
               tmds_pkg::CH_OPEN: begin
                  if (rdata == 8'd0) begin
                     scan_begin = 1'b1;
                     dir_in     = 1'b1;
                  end
               end
               tmds_pkg::CH_CLOSE: begin
                  if (rdata != 8'd0) begin
                     scan_begin = 1'b1;
                     dir_in     = 1'b0;
                  end
               end
               tmds_pkg::CH_DOT: begin
                  ob = rdata;
                  st = tmds_pkg::ST_OUTPUT;
               end
               default: ;
            endcase
            depth_in = '0;
            if (!scan_begin) begin
               rsp_valid_in = 1'b1;
               if (pc_ff == LAST) begin
                  st = tmds_pkg::ST_END;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
         end
      end

      if (ctl.scan_start) begin
         raddr       = pc_ff;
         chk_in      = pc_ff;
         scan_ptr_in = dir_ff ? pc_ff + 1'b1 : pc_ff - 1'b1;
      end

      // read one byte ahead, check the byte read last cycle
      if (ctl.scan_step) begin
         raddr       = scan_ptr_ff;
         chk_in      = scan_ptr_ff;
         scan_ptr_in = dir_ff ? scan_ptr_ff + 1'b1 : scan_ptr_ff - 1'b1;
         if (rdata == inc_ch) begin
            depth_in = depth_ff + 1'b1;
         end else if (rdata == dec_ch) begin
            depth_in = depth_ff - 1'b1;
         end
         if ((rdata == dec_ch) && (depth_ff == (AW + 1)'(1))) begin
            pc_in        = chk_ff;
            st           = tmds_pkg::ST_STEPPED;
            rsp_valid_in = 1'b1;
            scan_end     = 1'b1;
         end else if (dir_ff ? (chk_ff == LAST) : (chk_ff == '0)) begin
            st           = tmds_pkg::ST_UNMATCHED;
            rsp_valid_in = 1'b1;
            scan_end     = 1'b1;
         end
      end

      rsp_in.status          = st;
      rsp_in.out_byte        = ob;
      rsp_in.program_counter = 12'(pc_in);
      rsp_in.data_pointer    = 12'(dp_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         dp_ff        <= '0;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         plen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         dp_ff        <= dp_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            plen_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      bp_ff       <= bp_in;
      op_ff       <= op_in;
      ign_ff      <= ign_in;
      hit_ff      <= hit_in;
      dir_ff      <= dir_in;
      scan_ptr_ff <= scan_ptr_in;
      chk_ff      <= chk_in;
      depth_ff    <= depth_in;
      rsp_ff      <= rsp_in;
   end

   assign stat.clear_last = (clr_ff == LAST);
   assign stat.is_step    = (req_data.command == tmds_pkg::CMD_STEP);
   assign stat.scan_begin = scan_begin;
   assign stat.scan_end   = scan_end;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

>>> sv/tape_machine_debug_stepper.sv
`timescale 1ns / 1ps
// Load, breakpoint, restart and unused commands: result strobe the cycle after start,
// and a new command can be taken on every cycle while busy is low.
// Step: result registered after fetch op, fetch cell and execute, all on one RAM port;
// busy holds the next command off until then; a bracket jump adds a scan that walks
// the tape byte by byte. After reset busy stays high while the tape is cleared.
// The receiver cannot stall: each result shows for one cycle.
module tape_machine_debug_stepper #(
   parameter int TAPE_DEPTH  = tmds_pkg::TAPE_DEPTH_DEF,
   parameter int BREAK_SLOTS = tmds_pkg::BREAK_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tmds_pkg::req_type req_data,
   output logic              rsp_valid,
   output tmds_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [11:0]       csr_wdata
);

   tmds_pkg::ctl_type  ctl;
   tmds_pkg::stat_type stat;

   tmds_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctl   (ctl)
   );

   tmds_dpath #(.TAPE_DEPTH(TAPE_DEPTH), .BREAK_SLOTS(BREAK_SLOTS)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .stat      (stat),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
